// ----- sv/gcdn_pkg.sv -----
// gcdn_pkg: shared constants and controller/datapath interface types
// for the n-value gcd block. No dependencies.
`default_nettype none

package gcdn_pkg;

  // default width of one input integer
  localparam int GCDN_VALUE_WIDTH = 32;
  // width of the gcd result field
  localparam int GCDN_OUT_WIDTH   = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the new magnitude, start a reduction
    logic step;    // one binary gcd step (or settle when finished)
    logic shift;   // restore one common factor of two
    logic commit;  // store the reduced value as the running gcd
    logic emit;    // write the result register, clear the running gcd
  } gcdn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic done;      // reduction has reached its end
    logic k_zero;    // no common factors of two left to restore
    logic out_free;  // result register can take a new result
  } gcdn_sts_t;

endpackage

`default_nettype wire

// ----- sv/gcdn_dp.sv -----
// gcdn_dp: datapath of the gcd block: magnitude, binary gcd reduction,
// running gcd and the result register. Depends on gcdn_pkg.
`default_nettype none

module gcdn_dp #(
  parameter int VALUE_WIDTH = gcdn_pkg::GCDN_VALUE_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [VALUE_WIDTH-1:0]               in_value,
  input  wire gcdn_pkg::gcdn_cmd_t                  cmd,
  output gcdn_pkg::gcdn_sts_t                       sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [gcdn_pkg::GCDN_OUT_WIDTH-1:0]       out_gcd,
  output logic                                      out_undef
);
  import gcdn_pkg::*;

  localparam int KW = $clog2(VALUE_WIDTH);
  localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] run_r, run_nxt;
  logic                   out_valid_r;
  logic [GCDN_OUT_WIDTH-1:0] out_gcd_r;
  logic                   out_undef_r;

  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] diff_ab;
  logic [VALUE_WIDTH-1:0] diff_ba;
  logic [VALUE_WIDTH-1:0] res;
  logic                   done;
  logic [VALUE_WIDTH+GCDN_OUT_WIDTH-1:0] run_ext;

  // magnitude, most negative value maps to 2^(w-1) unsigned
  assign mag = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_value + ONE) : in_value;

  assign diff_ab = a_r - b_r;
  assign diff_ba = b_r - a_r;

  // end of reduction and its odd-part result
  assign done = (a_r == '0) || (b_r == '0) || (a_r == ONE) || (b_r == ONE);
  always_comb begin
    priority if (a_r == '0) begin
      res = b_r;
    end else if (b_r == '0) begin
      res = a_r;
    end else begin
      res = ONE;
    end
  end

  // reduction registers
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    if (cmd.load) begin
      a_nxt = run_r;
      b_nxt = mag;
      k_nxt = '0;
    end else if (cmd.step) begin
      priority if (done) begin
        a_nxt = res;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = diff_ab >> 1;
      end else begin
        b_nxt = diff_ba >> 1;
      end
    end else if (cmd.shift) begin
      a_nxt = a_r << 1;
      k_nxt = k_r - KW'(1);
    end
  end

  // running gcd of the current set
  always_comb begin
    run_nxt = run_r;
    if (cmd.commit) begin
      run_nxt = a_r;
    end else if (cmd.emit) begin
      run_nxt = '0;
    end
  end

  assign run_ext = {{GCDN_OUT_WIDTH{1'b0}}, run_r};

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // result register, holds until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_gcd_r   <= run_ext[GCDN_OUT_WIDTH-1:0];
      out_undef_r <= (run_r == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_gcd      = out_gcd_r;
  assign out_undef    = out_undef_r;
  assign sts.done     = done;
  assign sts.k_zero   = (k_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

`ifndef SYNTH
  // running gcd is cleared once a set has been emitted
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (run_r == '0))
    else $error("running gcd not cleared after emit");

  // a result is only written when the register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

  // a restore step doubles the value and uses up one factor of two
  a_shift_double: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |=> (a_r == ($past(a_r) << 1)) && (k_r == $past(k_r) - KW'(1)))
    else $error("restore step wrong");

  // an undefined result always carries a zero gcd
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_undef_r) |-> (out_gcd_r == '0))
    else $error("undefined result with nonzero gcd");
`endif

endmodule

`default_nettype wire

// ----- sv/gcdn_ctrl.sv -----
// gcdn_ctrl: controller state machine of the gcd block; sequences load,
// reduction, restore, commit and emit. Depends on gcdn_pkg.
`default_nettype none

module gcdn_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tlast,
  output logic                     in_tready,
  output gcdn_pkg::gcdn_cmd_t      cmd,
  input  wire gcdn_pkg::gcdn_sts_t sts
);
  import gcdn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_tlast;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sts.k_zero) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ----- sv/gcd_of_n_values_core.sv -----
// gcd_of_n_values_core: top level of the n-value gcd block; joins the
// controller and the datapath. Depends on gcdn_pkg, gcdn_ctrl, gcdn_dp.
//
// Usage: each in_ transfer carries one signed integer in in_tdata; in_tlast
// marks the final integer of a set. The block keeps the running gcd of the
// magnitudes of the set and, on the final integer, delivers one out_
// transfer: out_tdata holds the gcd, out_tuser flags a set of all zeros
// (gcd then reads 0). Other integers give no output transfer.
// Sequencing: one integer at a time. An item is loaded, then reduced by
// binary gcd steps until the reduction ends, then its common factors of
// two are restored, then the result is committed as the running gcd; a
// final integer then writes the result register, waiting while that
// register still holds a result the receiver has not taken.
// Reset (rst_n low, synchronous) clears the running gcd and empties the
// result register. If the receiver holds out_tready low, the result stays
// in its register; the block keeps taking integers of the next set and
// stalls only when the next result is due.
`default_nettype none

module gcd_of_n_values_core #(
  parameter int VALUE_WIDTH = gcdn_pkg::GCDN_VALUE_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: value [VALUE_WIDTH-1:0], zero padding to whole bytes
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   in_tdata,
  input  wire logic                               in_tlast,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: gcd_value [31:0]
  output logic [gcdn_pkg::GCDN_OUT_WIDTH-1:0]     out_tdata,
  // out_tuser: undefined [0]
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);
  import gcdn_pkg::*;

  gcdn_cmd_t cmd;
  gcdn_sts_t sts;

  // sequencing
  gcdn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and result register
  gcdn_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_gcd   (out_tdata),
    .out_undef (out_tuser)
  );

endmodule

`default_nettype wire
